>>> hdl/ihg_pkg.sv
package ihg_pkg;

    localparam int HDR_WORDS = 5;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HDR_WORDS - 1);
    localparam logic [15:0]      HDR_BYTES = 16'd20;
    localparam logic [7:0]       VER_IHL   = 8'h45;
    localparam logic [7:0]       TOS_VAL   = 8'h00;
    localparam logic [15:0]      FRAG_VAL  = 16'h0000;
    localparam logic [7:0]       TTL_RESET = 8'd30;
    localparam logic [15:0]      LEN_MAX   = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIME_TO_LIVE   = CFG_IDX_W'(1);

    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  protocol;
        logic [31:0] dest_address;
    } in_item_t;

    typedef struct packed {
        logic [31:0]      header_word;
        logic [IDX_W-1:0] word_index;
        logic             last_word;
        logic             length_overflow;
    } out_item_t;

    // descriptor held in the input register, with its identification
    typedef struct packed {
        in_item_t    item;
        logic [15:0] ident;
    } desc_t;

    typedef struct packed {
        logic [HDR_WORDS-1:0][31:0] words;
        logic                       overflow;
    } hdr_t;

endpackage

>>> hdl/ipv4_header_generator_unit.sv
// Channel  | Dir | Beat              | Handshake
// in       | in  | in_item_t         | in_valid / in_stall
// out      | out | out_item_t        | out_valid / out_stall
// cfg      | in  | index + 32b data  | cfg_valid / cfg_ready (always ready)
//
// Each descriptor yields five header beats on the 32-bit output channel.
// The next descriptor loads as the last beat is taken, so headers run
// back to back unless out_stall holds them. Output beats are registered.
// Input register holds the next descriptor while the current header drains.
// Async active-low reset: source address 0, TTL 30, identification 0.
module ipv4_header_generator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ihg_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ihg_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ihg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import ihg_pkg::*;

    logic [31:0] src_reg;
    logic [7:0]  ttl_reg;
    logic [15:0] ident_reg;
    logic        a_valid_reg;
    desc_t       a_reg;
    logic        load_ready;
    logic        in_take;
    hdr_t        hdr;

    assign cfg_ready = 1'b1;
    assign in_stall  = a_valid_reg && !load_ready;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= '0;
            ttl_reg <= TTL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SOURCE_ADDRESS: src_reg <= cfg_data;
                REG_TIME_TO_LIVE:   ttl_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            ident_reg   <= '0;
        end
        else if (in_take)
        begin
            a_valid_reg <= 1'b1;
            ident_reg   <= ident_reg + 16'd1;
        end
        else if (load_ready)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_reg.item  <= in_data;
            a_reg.ident <= ident_reg;
        end
    end

    ihg_build u_build (
        .desc           (a_reg),
        .source_address (src_reg),
        .time_to_live   (ttl_reg),
        .hdr            (hdr)
    );

    ihg_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (a_valid_reg),
        .load_ready (load_ready),
        .hdr        (hdr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

>>> hdl/ihg_build.sv
module ihg_build (
    input  ihg_pkg::desc_t  desc,
    input  logic [31:0]     source_address,
    input  logic [7:0]      time_to_live,
    output ihg_pkg::hdr_t   hdr
);
    import ihg_pkg::*;

    logic [16:0] total;
    logic        overflow;
    logic [15:0] total_len;
    logic [18:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] checksum;

    always_comb
    begin
        total     = {1'b0, desc.item.payload_length} + {1'b0, HDR_BYTES};
        overflow  = total[16];
        total_len = overflow ? LEN_MAX : total[15:0];

        // ones' complement sum of the header halves, checksum field as zero
        sum = 19'({VER_IHL, TOS_VAL}) + 19'(total_len) + 19'(desc.ident)
            + 19'(FRAG_VAL) + 19'({time_to_live, desc.item.protocol})
            + 19'(source_address[31:16]) + 19'(source_address[15:0])
            + 19'(desc.item.dest_address[31:16])
            + 19'(desc.item.dest_address[15:0]);
        // two end-around carries are enough for these nine terms
        fold1    = {1'b0, sum[15:0]} + 17'(sum[18:16]);
        fold2    = fold1[15:0] + 16'(fold1[16]);
        checksum = ~fold2;

        hdr.words[0] = {VER_IHL, TOS_VAL, total_len};
        hdr.words[1] = {desc.ident, FRAG_VAL};
        hdr.words[2] = {time_to_live, desc.item.protocol, checksum};
        hdr.words[3] = source_address;
        hdr.words[4] = desc.item.dest_address;
        hdr.overflow = overflow;
    end

endmodule

>>> hdl/ihg_serial.sv
module ihg_serial (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_valid,
    output logic               load_ready,
    input  ihg_pkg::hdr_t      hdr,
    output logic               out_valid,
    input  logic               out_stall,
    output ihg_pkg::out_item_t out_data
);
    import ihg_pkg::*;

    logic                       busy_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [HDR_WORDS-1:0][31:0] words_reg;
    logic                       ovf_reg;
    logic                       out_take;
    logic                       is_last;
    logic                       load;

    assign is_last    = (idx_reg == LAST_IDX);
    assign out_take   = busy_reg && !out_stall;
    assign load_ready = !busy_reg || (out_take && is_last);
    assign load       = load_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_take)
        begin
            if (is_last)
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // words shift toward slot 0, which is the beat on the port
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            words_reg <= hdr.words;
            ovf_reg   <= hdr.overflow;
        end
        else if (out_take)
        begin
            for (int i = 0; i < HDR_WORDS - 1; i++)
                words_reg[i] <= words_reg[i+1];
        end
    end

    assign out_valid                = busy_reg;
    assign out_data.header_word     = words_reg[0];
    assign out_data.word_index      = idx_reg;
    assign out_data.last_word       = is_last;
    assign out_data.length_overflow = ovf_reg;

endmodule

>>> hdl/ihg_checker.sv
module ihg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ihg_pkg::out_item_t out_data
);
    import ihg_pkg::*;

    logic out_take;
    assign out_take = out_valid && !out_stall;

    // within a header the beats run back to back in index order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !out_data.last_word |=>
            out_valid && out_data.word_index == $past(out_data.word_index) + IDX_W'(1))
        else $error("header beat index did not advance");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.last_word == (out_data.word_index == LAST_IDX))
        else $error("last_word disagrees with word_index");

    a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !out_data.last_word |=>
            out_data.length_overflow == $past(out_data.length_overflow))
        else $error("length_overflow changed inside a header");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

endmodule

bind ipv4_header_generator_unit ihg_checker u_ihg_checker (.*);
